>>> rtl/grouped_interrupt_controller_top_macros.svh
`ifndef GROUPED_INTERRUPT_CONTROLLER_TOP_MACROS_SVH
`define GROUPED_INTERRUPT_CONTROLLER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define GIC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gic assertion failed");

// Next-cycle implication.
`define GIC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gic assertion failed");

// Delayed implication: the consequent is checked later than the antecedent.
`define GIC_ASSERT_LAT2(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##2 (cons)) \
		else $error("gic assertion failed");

`endif

>>> rtl/gic_pkg.sv
package gic_pkg;

	localparam int GROUPS     = 4;
	localparam int LINES      = 8;
	localparam int LINE_IDX_W = $clog2(LINES);
	localparam int SRC_W      = 32;
	localparam int VEC_W      = 5;
	localparam int EXT_W      = GROUPS * LINES;

	typedef logic [LINES-1:0] line_vec_t;

	localparam line_vec_t ALL_ONES = '1;

	typedef logic [1:0] func_t;
	localparam func_t FUNC_WRITE = 2'd0;
	localparam func_t FUNC_READ  = 2'd1;
	localparam func_t FUNC_TICK  = 2'd2;

	typedef logic [1:0] sel_t;
	localparam sel_t SEL_PENDING = 2'd0;
	localparam sel_t SEL_EDGE    = 2'd1;
	localparam sel_t SEL_MASK    = 2'd2;

	typedef struct packed {
		func_t            func;
		logic [1:0]       group_index;
		sel_t             reg_select;
		line_vec_t        write_data;
		logic [SRC_W-1:0] source_lines;
	} op_t;

	typedef struct packed {
		line_vec_t        read_data;
		logic             irq;
		logic             vector_valid;
		logic [VEC_W-1:0] vector_index;
	} res_t;

	// index of the lowest set bit; 0 when none is set
	function automatic logic [LINE_IDX_W-1:0] first_set(input line_vec_t w);
		logic [LINE_IDX_W-1:0] idx;
		idx = '0;
		for (int b = LINES - 1; b >= 0; b--) begin
			if (w[b]) begin
				idx = LINE_IDX_W'(b);
			end
		end
		return idx;
	endfunction

endpackage

>>> rtl/grouped_interrupt_controller_top.sv
// Path from the input beat to its result beat: input register (op_s1), then result register (res_q).
// Throughput: one beat per cycle while out_ready is high; the register update and the
// vector search for a beat both sit between the input register and the result register.
// Reset (arst_n low, asynchronous): pending clear, mask and edge mode all ones,
// last sampled sources zero, both pipeline stages empty.
module grouped_interrupt_controller_top import gic_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       func,
	input  logic [1:0]       group_index,
	input  logic [1:0]       reg_select,
	input  logic [7:0]       write_data,
	input  logic [SRC_W-1:0] source_lines,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       read_data,
	output logic             irq,
	output logic             vector_valid,
	output logic [VEC_W-1:0] vector_index
);

	op_t  op_s1;
	logic valid_s1;
	res_t res_d;
	res_t res_q;
	logic out_valid_q;
	logic advance;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	gic_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.op      (op_s1),
		.res     (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1.func         <= func;
			op_s1.group_index  <= group_index;
			op_s1.reg_select   <= reg_select;
			op_s1.write_data   <= write_data;
			op_s1.source_lines <= source_lines;
		end
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign read_data    = res_q.read_data;
	assign irq          = res_q.irq;
	assign vector_valid = res_q.vector_valid;
	assign vector_index = res_q.vector_index;

endmodule

>>> rtl/gic_regs.sv
module gic_regs import gic_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic advance,
	input  op_t  op,
	output res_t res
);

	line_vec_t        pend_q [GROUPS];
	line_vec_t        mask_q [GROUPS];
	line_vec_t        edge_q [GROUPS];
	logic [SRC_W-1:0] last_src_q;

	line_vec_t        pend_d [GROUPS];
	line_vec_t        mask_d [GROUPS];
	line_vec_t        edge_d [GROUPS];
	line_vec_t        now_g  [GROUPS];
	line_vec_t        prev_g [GROUPS];
	line_vec_t        set_g  [GROUPS];
	line_vec_t        live_g [GROUPS];

	logic [EXT_W-1:0] src_now;
	logic [EXT_W-1:0] src_prev;
	line_vec_t        rd;
	logic             found;
	logic [VEC_W-1:0] vec;

	// groups past the 32 source bits see their lines low
	assign src_now  = EXT_W'(op.source_lines);
	assign src_prev = EXT_W'(last_src_q);

	always_comb begin
		rd = '0;
		for (int g = 0; g < GROUPS; g++) begin
			pend_d[g] = pend_q[g];
			mask_d[g] = mask_q[g];
			edge_d[g] = edge_q[g];
			now_g[g]  = src_now[g*LINES +: LINES];
			prev_g[g] = src_prev[g*LINES +: LINES];
			// edge lines set on a rising edge, level lines while high
			set_g[g]  = (edge_q[g] & now_g[g] & ~prev_g[g]) | (~edge_q[g] & now_g[g]);
			case (op.func)
				FUNC_WRITE: begin
					if (32'(op.group_index) == g) begin
						case (op.reg_select)
							SEL_PENDING: pend_d[g] = pend_q[g] & ~op.write_data;
							SEL_EDGE:    edge_d[g] = op.write_data;
							SEL_MASK:    mask_d[g] = op.write_data;
							default:     ;
						endcase
					end
				end
				FUNC_READ: begin
					if (32'(op.group_index) == g) begin
						case (op.reg_select)
							SEL_PENDING: rd = pend_q[g];
							SEL_EDGE:    rd = edge_q[g];
							SEL_MASK:    rd = mask_q[g];
							default:     ;
						endcase
					end
				end
				FUNC_TICK: pend_d[g] = pend_q[g] | set_g[g];
				default:   ;
			endcase
			live_g[g] = pend_d[g] & ~mask_d[g];
		end
	end

	// lowest group wins: scan from the top down
	always_comb begin
		found = 1'b0;
		vec   = '0;
		for (int g = GROUPS - 1; g >= 0; g--) begin
			if (|live_g[g]) begin
				found = 1'b1;
				vec   = VEC_W'(g * LINES + int'(first_set(live_g[g])));
			end
		end
	end

	assign res.read_data    = rd;
	assign res.irq          = found;
	assign res.vector_valid = found;
	assign res.vector_index = vec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < GROUPS; g++) begin
				pend_q[g] <= '0;
				mask_q[g] <= ALL_ONES;
				edge_q[g] <= ALL_ONES;
			end
			last_src_q <= '0;
		end else if (advance) begin
			for (int g = 0; g < GROUPS; g++) begin
				pend_q[g] <= pend_d[g];
				mask_q[g] <= mask_d[g];
				edge_q[g] <= edge_d[g];
			end
			if (op.func == FUNC_TICK) begin
				last_src_q <= op.source_lines;
			end
		end
	end

endmodule

>>> rtl/gic_checker.sv
`include "grouped_interrupt_controller_top_macros.svh"

module gic_checker import gic_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic [1:0]       func,
	input logic [1:0]       group_index,
	input logic [1:0]       reg_select,
	input logic [7:0]       write_data,
	input logic [SRC_W-1:0] source_lines,
	input logic             out_valid,
	input logic             out_ready,
	input logic [7:0]       read_data,
	input logic             irq,
	input logic             vector_valid,
	input logic [VEC_W-1:0] vector_index
);

	// a stalled result beat holds
	`GIC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(read_data) && $stable(irq) && $stable(vector_index))

	`GIC_ASSERT_NOW(a_irq_matches_vec, out_valid, irq == vector_valid)

	`GIC_ASSERT_NOW(a_no_vec_zero_idx, out_valid && !vector_valid, vector_index == '0)

	// an accepted beat shows up at the output after the input and result registers, or the output is stalled
	`GIC_ASSERT_LAT2(a_latency, in_valid && in_ready, out_valid)

endmodule

bind grouped_interrupt_controller_top gic_checker u_gic_checker (.*);
